### rtl/mrr_pkg.sv
// Shared types, register indexes and helpers for the reaction-rate pipeline.
// Depends on nothing; used by meinhardt_reaction_rates_core.
`timescale 1ns / 1ps
`default_nettype none
package mrr_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_DE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FC     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MURHO0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NURHO1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_C0GAM  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_EPS    = 3'd5;

    localparam int unsigned CFG_DATA_W = 48;
    localparam int unsigned LEVEL_W    = 24;
    localparam int unsigned RATE_W     = 32;

    localparam logic signed [RATE_W-1:0] RATE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [RATE_W-1:0] RATE_MIN = 32'sh8000_0000;

    // One cell's levels, unsigned Q8.16
    typedef struct packed {
        logic [LEVEL_W-1:0] vein_level;
        logic [LEVEL_W-1:0] activator_level;
        logic [LEVEL_W-1:0] inhibitor_level;
        logic [LEVEL_W-1:0] substrate_level;
    } t_in_item;

    // Rates, signed Q16.16, plus the zero-inhibitor flag
    typedef struct packed {
        logic signed [RATE_W-1:0] vein_rate;
        logic signed [RATE_W-1:0] activator_rate;
        logic signed [RATE_W-1:0] inhibitor_rate;
        logic signed [RATE_W-1:0] substrate_rate;
        logic                     zero_inhibitor;
    } t_out_item;

    // Clamp a wide signed sum to the rate range
    function automatic logic signed [RATE_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [RATE_W-1:0] res;
        if (v > 64'sd2147483647) begin
            res = RATE_MAX;
        end else if (v < -64'sd2147483648) begin
            res = RATE_MIN;
        end else begin
            res = v[RATE_W-1:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

### rtl/meinhardt_reaction_rates_core.sv
// Pipelined reaction-rate datapath for one cell of the activator-inhibitor-substrate model.
// Depends on mrr_pkg (item types, register indexes, saturation helper).
`timescale 1ns / 1ps
`default_nettype none
// Takes one cell's levels (Y, A, H, S in unsigned Q8.16) per cycle and returns the four
// rates of change in signed Q16.16, each saturated. Throughput is one transaction per
// cycle; from input acceptance to result valid a transaction passes through four multiply
// stages, one setup stage, two radix-2 restoring dividers running side by side (34
// stages for A*A*S*c/H, 32 of them used by the vein saturation quotient) and an output
// register. When H is zero the activator rate reads 0x7FFFFFFF and zero_inhibitor is set.
// The whole pipe advances together; it holds while the output register is full and not
// taken. The user must write coefficients through the cfg port only while no transaction
// is in flight; the block does not enforce this. o_cfg_ready is always high.
module meinhardt_reaction_rates_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire mrr_pkg::t_in_item                  i_in_data,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output mrr_pkg::t_out_item                      o_out_data,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [mrr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [mrr_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import mrr_pkg::*;

    localparam int unsigned NDIV = 34;          // activator quotient bits
    localparam int unsigned NVDIV = 32;         // vein quotient bits
    localparam int unsigned NST = 4 + NDIV + 2; // total valid stages

    typedef struct packed {
        logic [40:0]        vrem;
        logic [31:0]        vq;
        logic [40:0]        vden;
        logic [23:0]        arem;
        logic [33:0]        aq;
        logic [23:0]        ah;
        logic               aovf;
        logic               azero;
        logic signed [33:0] dy_lin;
        logic signed [33:0] da_lin;
        logic [31:0]        dh;
        logic [31:0]        ds;
    } t_div_stage;

    // Coefficient registers
    logic [CFG_DATA_W-1:0] r_coef_de, r_coef_fc, r_coef_murho0, r_coef_nurho1, r_coef_c0gam;
    logic [LEVEL_W-1:0]    r_coef_eps;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_de     <= '0;
            r_coef_fc     <= '0;
            r_coef_murho0 <= '0;
            r_coef_nurho1 <= '0;
            r_coef_c0gam  <= '0;
            r_coef_eps    <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DE:     r_coef_de     <= i_cfg_data;
                CFG_FC:     r_coef_fc     <= i_cfg_data;
                CFG_MURHO0: r_coef_murho0 <= i_cfg_data;
                CFG_NURHO1: r_coef_nurho1 <= i_cfg_data;
                CFG_C0GAM:  r_coef_c0gam  <= i_cfg_data;
                CFG_EPS:    r_coef_eps    <= i_cfg_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    logic [23:0] cf_d, cf_e, cf_f, cf_c, cf_mu, cf_rho0, cf_nu, cf_rho1, cf_c0, cf_gam;
    assign cf_d    = r_coef_de[47:24];
    assign cf_e    = r_coef_de[23:0];
    assign cf_f    = r_coef_fc[47:24];
    assign cf_c    = r_coef_fc[23:0];
    assign cf_mu   = r_coef_murho0[47:24];
    assign cf_rho0 = r_coef_murho0[23:0];
    assign cf_nu   = r_coef_nurho1[47:24];
    assign cf_rho1 = r_coef_nurho1[23:0];
    assign cf_c0   = r_coef_c0gam[47:24];
    assign cf_gam  = r_coef_c0gam[23:0];

    // Pipe control: everything moves when the output register can take a result
    logic [NST-1:0] r_vld;
    logic           en;
    assign en          = !r_vld[NST-1] || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], i_in_valid};
        end
    end

    // Stage 1: the 24x24 products
    logic [47:0] m_yy, m_aa, m_ys, m_da, m_ey, m_mua, m_rho0y, m_nuh, m_rho1y, m_gams;
    logic [31:0] r1_y2, r1_aa, r1_ys, r1_da, r1_ey, r1_mua, r1_rho0y, r1_nuh, r1_rho1y;
    logic [31:0] r1_gams;
    logic [23:0] r1_s, r1_h;

    always_comb begin
        m_yy    = 48'(i_in_data.vein_level) * 48'(i_in_data.vein_level);
        m_aa    = 48'(i_in_data.activator_level) * 48'(i_in_data.activator_level);
        m_ys    = 48'(i_in_data.vein_level) * 48'(i_in_data.substrate_level);
        m_da    = 48'(cf_d) * 48'(i_in_data.activator_level);
        m_ey    = 48'(cf_e) * 48'(i_in_data.vein_level);
        m_mua   = 48'(cf_mu) * 48'(i_in_data.activator_level);
        m_rho0y = 48'(cf_rho0) * 48'(i_in_data.vein_level);
        m_nuh   = 48'(cf_nu) * 48'(i_in_data.inhibitor_level);
        m_rho1y = 48'(cf_rho1) * 48'(i_in_data.vein_level);
        m_gams  = 48'(cf_gam) * 48'(i_in_data.substrate_level);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_y2    <= m_yy[47:16];
            r1_aa    <= m_aa[47:16];
            r1_ys    <= m_ys[47:16];
            r1_da    <= m_da[47:16];
            r1_ey    <= m_ey[47:16];
            r1_mua   <= m_mua[47:16];
            r1_rho0y <= m_rho0y[47:16];
            r1_nuh   <= m_nuh[47:16];
            r1_rho1y <= m_rho1y[47:16];
            r1_gams  <= m_gams[47:16];
            r1_s     <= i_in_data.substrate_level;
            r1_h     <= i_in_data.inhibitor_level;
        end
    end

    // Stage 2: second-level products and linear partial sums
    logic [55:0] m_fy2, m_aas, m_epsys;
    logic [39:0] r2_fy2, r2_aas, r2_epsys;
    logic [31:0] r2_y2;
    logic [23:0] r2_h;
    logic signed [33:0] r2_dy_lin, r2_da_lin, r2_dh_lin, r2_ds_part;

    always_comb begin
        m_fy2   = 56'(cf_f) * 56'(r1_y2);
        m_aas   = 56'(r1_s) * 56'(r1_aa);
        m_epsys = 56'(r_coef_eps) * 56'(r1_ys);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_fy2     <= m_fy2[55:16];
            r2_aas     <= m_aas[55:16];
            r2_epsys   <= m_epsys[55:16];
            r2_y2      <= r1_y2;
            r2_h       <= r1_h;
            r2_dy_lin  <= $signed({2'b0, r1_da}) - $signed({2'b0, r1_ey});
            r2_da_lin  <= $signed({2'b0, r1_rho0y}) - $signed({2'b0, r1_mua});
            r2_dh_lin  <= $signed({2'b0, r1_rho1y}) - $signed({2'b0, r1_nuh});
            r2_ds_part <= $signed({10'b0, cf_c0}) - $signed({2'b0, r1_gams});
        end
    end

    // Stage 3: c * A*A*S split in two halves, vein denominator, substrate rate
    logic [43:0] r3_p_lo, r3_p_hi;
    logic [40:0] r3_den;
    logic [31:0] r3_y2, r3_ds;
    logic [23:0] r3_h;
    logic signed [33:0] r3_dy_lin, r3_da_lin, r3_dh_lin;
    logic signed [63:0] n3_ds;

    assign n3_ds = 64'(r2_ds_part) - $signed({24'b0, r2_epsys});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_p_lo   <= 44'(r2_aas[19:0]) * 44'(cf_c);
            r3_p_hi   <= 44'(r2_aas[39:20]) * 44'(cf_c);
            r3_den    <= 41'd65536 + 41'(r2_fy2);
            r3_ds     <= sat32(n3_ds);
            r3_y2     <= r2_y2;
            r3_h      <= r2_h;
            r3_dy_lin <= r2_dy_lin;
            r3_da_lin <= r2_da_lin;
            r3_dh_lin <= r2_dh_lin;
        end
    end

    // Stage 4: recombine the production term
    logic [63:0] n4_psum;
    logic [47:0] r4_prod;
    logic [40:0] r4_den;
    logic [31:0] r4_y2, r4_ds;
    logic [23:0] r4_h;
    logic signed [33:0] r4_dy_lin, r4_da_lin, r4_dh_lin;

    assign n4_psum = {r3_p_hi, 20'b0} + 64'(r3_p_lo);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_prod   <= n4_psum[63:16];
            r4_den    <= r3_den;
            r4_y2     <= r3_y2;
            r4_ds     <= r3_ds;
            r4_h      <= r3_h;
            r4_dy_lin <= r3_dy_lin;
            r4_da_lin <= r3_da_lin;
            r4_dh_lin <= r3_dh_lin;
        end
    end

    // Stage 5 (divider entry) and divider steps
    t_div_stage r_div [0:NDIV];
    t_div_stage n_div [0:NDIV];
    logic signed [63:0] n5_dh;

    assign n5_dh = $signed({16'b0, r4_prod}) + 64'(r4_dh_lin);

    always_comb begin
        logic [41:0] vt;
        logic [24:0] at;
        logic        vge, age;
        // quotient would need more than 34 bits (always so when H is zero)
        n_div[0].aovf   = (r4_prod[47:18] >= {6'b0, r4_h});
        n_div[0].azero  = (r4_h == '0);
        n_div[0].arem   = r4_prod[41:18];
        n_div[0].aq     = {r4_prod[17:0], 16'b0};
        n_div[0].ah     = r4_h;
        n_div[0].vrem   = {25'b0, r4_y2[31:16]};
        n_div[0].vq     = {r4_y2[15:0], 16'b0};
        n_div[0].vden   = r4_den;
        n_div[0].dy_lin = r4_dy_lin;
        n_div[0].da_lin = r4_da_lin;
        n_div[0].dh     = sat32(n5_dh);
        n_div[0].ds     = r4_ds;
        for (int k = 1; k <= NDIV; k++) begin
            n_div[k] = r_div[k-1];
            // activator quotient bit
            at  = {r_div[k-1].arem, r_div[k-1].aq[33]};
            age = (at >= {1'b0, r_div[k-1].ah});
            n_div[k].arem = age ? 24'(at - {1'b0, r_div[k-1].ah}) : at[23:0];
            n_div[k].aq   = {r_div[k-1].aq[32:0], age};
            // vein quotient bit, only in the first NVDIV steps
            vt  = {r_div[k-1].vrem, r_div[k-1].vq[31]};
            vge = (vt >= {1'b0, r_div[k-1].vden});
            if (k <= NVDIV) begin
                n_div[k].vrem = vge ? 41'(vt - {1'b0, r_div[k-1].vden}) : vt[40:0];
                n_div[k].vq   = {r_div[k-1].vq[30:0], vge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k <= NDIV; k++) begin
                r_div[k] <= n_div[k];
            end
        end
    end

    // Output stage: final sums and saturation
    logic [33:0]        n_qc;
    logic signed [63:0] n_dy, n_da;
    t_out_item          r_out;

    always_comb begin
        n_qc = (r_div[NDIV].aovf || r_div[NDIV].aq[33]) ? 34'h2_0000_0000 : r_div[NDIV].aq;
        n_dy = 64'(r_div[NDIV].dy_lin) + $signed({32'b0, r_div[NDIV].vq});
        n_da = 64'(r_div[NDIV].da_lin) + $signed({30'b0, n_qc});
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.vein_rate      <= sat32(n_dy);
            r_out.activator_rate <= r_div[NDIV].azero ? RATE_MAX : sat32(n_da);
            r_out.inhibitor_rate <= r_div[NDIV].dh;
            r_out.substrate_rate <= r_div[NDIV].ds;
            r_out.zero_inhibitor <= r_div[NDIV].azero;
        end
    end

    assign o_out_data = r_out;

    // Checks
    a_flag_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.zero_inhibitor |-> o_out_data.activator_rate == RATE_MAX)
        else $error("zero inhibitor flag without saturated activator rate");

    a_den_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> r3_den >= 41'd65536)
        else $error("vein denominator below one");

    a_vrem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NST-2] |-> r_div[NDIV].vrem < r_div[NDIV].vden)
        else $error("vein divider remainder out of range");

    a_arem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NST-2] && !r_div[NDIV].aovf |-> r_div[NDIV].arem < r_div[NDIV].ah)
        else $error("activator divider remainder out of range");

    a_zero_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NST-2] && r_div[NDIV].azero |-> r_div[NDIV].aovf)
        else $error("zero inhibitor not marked as quotient overflow");

endmodule
`default_nettype wire

### verif/tb_meinhardt_reaction_rates_core.sv
// Self-checking testbench for meinhardt_reaction_rates_core: directed and random cells,
// coefficient sweeps and backpressure. Depends on rtl/mrr_pkg.sv and the core RTL.
`timescale 1ns / 1ps
module tb_meinhardt_reaction_rates_core;
    import mrr_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;  // index the core ignores
    localparam int unsigned DRAIN_CYCLES = 48;              // pipe latency plus margin
    localparam logic signed [127:0] SUM_HI = 128'sd2147483647;
    localparam logic signed [127:0] SUM_LO = -128'sd2147483648;
    localparam logic [127:0] QUOT_LIMIT = 128'h2_0000_0000;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    t_in_item in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out_item out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow copy of the coefficient registers
    logic [CFG_DATA_W-1:0] coef_regs [0:5];

    t_out_item rate_queue [$];
    int unsigned fail_count = 0;
    int unsigned cells_sent = 0;
    int unsigned rates_checked = 0;
    int unsigned zero_h_seen = 0;
    bit idle_en = 1'b1;
    bit long_hold_req = 1'b0;
    int unsigned hold_cnt = 0;
    int unsigned stall_left = 0;

    meinhardt_reaction_rates_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Q.16 product, truncated
    function automatic logic [127:0] q16_mul(input logic [127:0] a, input logic [127:0] b);
        return (a * b) >> 16;
    endfunction

    function automatic logic signed [RATE_W-1:0] clamp_rate(input logic signed [127:0] v);
        if (v > SUM_HI) return RATE_MAX;
        if (v < SUM_LO) return RATE_MIN;
        return v[RATE_W-1:0];
    endfunction

    // Expected rates of one cell under the current coefficients
    function automatic t_out_item cell_rates(input t_in_item levels);
        logic [127:0] y, a, h, s, d, e, f, c, mu, rho0, nu, rho1, c0, gam, eps;
        logic [127:0] y2, den, vsat, prod, quot;
        logic signed [127:0] sum;
        t_out_item r;
        y = 128'(levels.vein_level); a = 128'(levels.activator_level);
        h = 128'(levels.inhibitor_level); s = 128'(levels.substrate_level);
        d = 128'(coef_regs[CFG_DE][47:24]);      e = 128'(coef_regs[CFG_DE][23:0]);
        f = 128'(coef_regs[CFG_FC][47:24]);      c = 128'(coef_regs[CFG_FC][23:0]);
        mu = 128'(coef_regs[CFG_MURHO0][47:24]); rho0 = 128'(coef_regs[CFG_MURHO0][23:0]);
        nu = 128'(coef_regs[CFG_NURHO1][47:24]); rho1 = 128'(coef_regs[CFG_NURHO1][23:0]);
        c0 = 128'(coef_regs[CFG_C0GAM][47:24]);  gam = 128'(coef_regs[CFG_C0GAM][23:0]);
        eps = 128'(coef_regs[CFG_EPS][23:0]);

        // vein marker with saturating self-activation
        y2 = q16_mul(y, y);
        den = 128'd65536 + q16_mul(f, y2);
        vsat = (y2 << 16) / den;
        sum = $signed(q16_mul(d, a)) - $signed(q16_mul(e, y)) + $signed(vsat);
        r.vein_rate = clamp_rate(sum);

        prod = q16_mul(q16_mul(q16_mul(a, a), s), c);

        // activator: division by H, pinned high when H is zero
        if (h == 0) begin
            r.activator_rate = RATE_MAX;
            r.zero_inhibitor = 1'b1;
        end else begin
            quot = (prod << 16) / h;
            if (quot > QUOT_LIMIT) quot = QUOT_LIMIT;
            sum = $signed(quot) - $signed(q16_mul(mu, a)) + $signed(q16_mul(rho0, y));
            r.activator_rate = clamp_rate(sum);
            r.zero_inhibitor = 1'b0;
        end

        sum = $signed(prod) - $signed(q16_mul(nu, h)) + $signed(q16_mul(rho1, y));
        r.inhibitor_rate = clamp_rate(sum);

        sum = $signed(c0) - $signed(q16_mul(gam, s)) - $signed(q16_mul(eps, q16_mul(y, s)));
        r.substrate_rate = clamp_rate(sum);
        return r;
    endfunction

    // Receiver: random stall bursts, plus a long hold on request
    always @(posedge i_clk) begin
        if (long_hold_req && hold_cnt == 0) begin
            out_ready <= 1'b0;
            hold_cnt <= 300;
        end else if (hold_cnt > 0) begin
            out_ready <= 1'b0;
            hold_cnt <= hold_cnt - 1;
        end else if (stall_left > 0) begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_en && $urandom_range(0, 6) == 0) begin
            out_ready <= 1'b0;
            stall_left <= $urandom_range(0, 4);
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Result checker: compare each transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_valid && out_ready) begin
            if (rate_queue.size() == 0) begin
                $display("%0t: unexpected result %h", $time, out_data);
                fail_count++;
            end else begin
                want = rate_queue.pop_front();
                rates_checked++;
                if (want.zero_inhibitor) zero_h_seen++;
                if (out_data.vein_rate !== want.vein_rate) begin
                    $display("%0t: vein_rate exp %h got %h", $time,
                             want.vein_rate, out_data.vein_rate);
                    fail_count++;
                end
                if (out_data.activator_rate !== want.activator_rate) begin
                    $display("%0t: activator_rate exp %h got %h", $time,
                             want.activator_rate, out_data.activator_rate);
                    fail_count++;
                end
                if (out_data.inhibitor_rate !== want.inhibitor_rate) begin
                    $display("%0t: inhibitor_rate exp %h got %h", $time,
                             want.inhibitor_rate, out_data.inhibitor_rate);
                    fail_count++;
                end
                if (out_data.substrate_rate !== want.substrate_rate) begin
                    $display("%0t: substrate_rate exp %h got %h", $time,
                             want.substrate_rate, out_data.substrate_rate);
                    fail_count++;
                end
                if (out_data.zero_inhibitor !== want.zero_inhibitor) begin
                    $display("%0t: zero_inhibitor exp %b got %b", $time,
                             want.zero_inhibitor, out_data.zero_inhibitor);
                    fail_count++;
                end
            end
        end
    end

    // Offer one cell; valid stays high between back-to-back transactions
    task automatic send_cell(input t_in_item levels);
        int unsigned gap;
        if (idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= levels;
        do @(posedge i_clk); while (!in_ready);
        rate_queue.push_back(cell_rates(levels));
        cells_sent++;
    endtask

    // Drop valid at the accepting edge and wait for the pipe to empty
    task automatic wait_idle();
        int unsigned guard;
        guard = 0;
        in_valid <= 1'b0;
        while (rate_queue.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_coef(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx <= CFG_EPS) coef_regs[idx] = val;
        @(posedge i_clk);
    endtask

    task automatic write_all_coefs(input logic [CFG_DATA_W-1:0] val);
        write_coef(CFG_DE, val);
        write_coef(CFG_FC, val);
        write_coef(CFG_MURHO0, val);
        write_coef(CFG_NURHO1, val);
        write_coef(CFG_C0GAM, val);
        write_coef(CFG_EPS, val);
    endtask

    function automatic logic [LEVEL_W-1:0] rand_level();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return LEVEL_MAX;
            2: return LEVEL_W'($urandom_range(0, 255));
            3: return LEVEL_W'($urandom_range(0, 1 << 18));
            default: return LEVEL_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_coef();
        logic [CFG_DATA_W-1:0] v;
        v = CFG_DATA_W'({$urandom, $urandom});
        case ($urandom_range(0, 3))
            0: v = v & 48'h03FFFF_03FFFF;   // small coefficients, fewer saturations
            1: v = v & 48'h00FFFF_00FFFF;
            default: ;
        endcase
        return v;
    endfunction

    function automatic t_in_item rand_cell();
        t_in_item levels;
        levels.vein_level = rand_level();
        levels.activator_level = rand_level();
        levels.inhibitor_level = rand_level();
        levels.substrate_level = rand_level();
        return levels;
    endfunction

    // Field extremes and special cases under zero, typical and full coefficients
    task automatic test_directed();
        t_in_item levels;
        write_all_coefs('0);
        send_cell('0);
        send_cell('1);
        wait_idle();
        write_coef(CFG_UNMAPPED, '1);          // ignored index
        send_cell('1);
        wait_idle();
        write_coef(CFG_DE, {24'h010000, 24'h008000});
        write_coef(CFG_FC, {24'h000000, 24'h010000});  // f = 0: bare Y*Y term
        write_coef(CFG_MURHO0, {24'h004000, 24'h000100});
        write_coef(CFG_NURHO1, {24'h008000, 24'h000200});
        write_coef(CFG_C0GAM, {24'h010000, 24'h001000});
        write_coef(CFG_EPS, 48'h000800);
        levels = '{24'h010000, 24'h020000, 24'h000000, 24'h030000};   // zero inhibitor
        send_cell(levels);
        levels = '{24'h010000, 24'h000000, 24'h000000, 24'h000000};   // zero H, zero product
        send_cell(levels);
        levels = '{LEVEL_MAX, LEVEL_MAX, 24'h000001, LEVEL_MAX};      // quotient capped
        send_cell(levels);
        levels = '{LEVEL_MAX, 24'h000000, LEVEL_MAX, 24'h000000};     // large vein term
        send_cell(levels);
        levels = '{24'h008000, 24'h018000, 24'h010000, 24'h020000};
        send_cell(levels);
        wait_idle();
        write_all_coefs('1);
        levels = '{LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX};
        send_cell(levels);
        levels = '{LEVEL_MAX, 24'h000000, LEVEL_MAX, LEVEL_MAX};      // substrate floor
        send_cell(levels);
        levels = '{24'h000000, LEVEL_MAX, 24'h000000, LEVEL_MAX};
        send_cell(levels);
        levels = '{24'h000001, 24'h000001, 24'h000001, 24'h000001};
        send_cell(levels);
        wait_idle();
    endtask

    // Random cells over a series of coefficient settings
    task automatic test_random_sweep(input int unsigned phases, input int unsigned per_phase);
        for (int p = 0; p < phases; p++) begin
            case (p % 4)
                0: write_all_coefs('1);
                1: write_all_coefs('0);
                default: begin
                    write_coef(CFG_DE, rand_coef());
                    write_coef(CFG_FC, rand_coef());
                    write_coef(CFG_MURHO0, rand_coef());
                    write_coef(CFG_NURHO1, rand_coef());
                    write_coef(CFG_C0GAM, rand_coef());
                    write_coef(CFG_EPS, rand_coef());
                end
            endcase
            repeat (per_phase) send_cell(rand_cell());
            wait_idle();
        end
    endtask

    // Receiver holds off for a long stretch while cells keep coming
    task automatic test_backpressure();
        long_hold_req <= 1'b1;
        @(posedge i_clk);
        long_hold_req <= 1'b0;
        repeat (200) send_cell(rand_cell());
        wait_idle();
    endtask

    initial begin
        for (int i = 0; i <= 5; i++) coef_regs[i] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_sweep(8, 160);
        test_backpressure();
        test_random_sweep(4, 100);
        idle_en = 1'b0;
        test_random_sweep(2, 100);
        $display("Checked %0d of %0d cells (%0d with zero inhibitor)",
                 rates_checked, cells_sent, zero_h_seen);
        $display("Covered field extremes, coefficient sweeps, stalls and a long hold");
        if (fail_count == 0 && rate_queue.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("== FAIL ==");
        $finish;
    end
endmodule
